// ----- rtl/core/fpa_pkg.sv -----
// Shared types, constants and helpers of the fixed-point ALU.
package fpa_pkg;

  localparam int FRAC_BITS = 8;
  localparam int DATA_W    = 32;
  // One restoring-division step per quotient bit; quotients of 2^33 and up saturate early.
  localparam int DIV_STEPS = 33;
  // Operand capture, divider steps, rounding stage.
  localparam int PIPE_LAT  = DIV_STEPS + 2;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0,  OP_SUB = 4'd1,  OP_MUL = 4'd2,  OP_DIV = 4'd3,
    OP_GT  = 4'd4,  OP_LT  = 4'd5,  OP_GE  = 4'd6,  OP_LE  = 4'd7,
    OP_EQ  = 4'd8,  OP_NE  = 4'd9,  OP_MIN = 4'd10, OP_MAX = 4'd11,
    OP_INC = 4'd12, OP_DEC = 4'd13, OP_I2F = 4'd14, OP_F2I = 4'd15
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_SAT     = 2'd1,
    ST_DIVZERO = 2'd2
  } status_t;

  // Per-beat side data that travels alongside the divider.
  typedef struct packed {
    logic                     valid;
    op_t                      op;
    logic signed [DATA_W-1:0] res;
    logic                     cmp;
    status_t                  st;
  } meta_t;

  // One row of the division pipeline.
  typedef struct packed {
    logic [DATA_W-1:0]    rem;
    logic [DIV_STEPS-1:0] nlow;
    logic [DIV_STEPS-1:0] quo;
    logic [DATA_W-1:0]    dvs;
    logic                 neg;
    logic                 ovf;
  } div_step_t;

  typedef struct packed {
    logic              sat;
    logic [DATA_W-1:0] val;
  } clamp_t;

  // Clamp a sign/magnitude value to the 32-bit signed range.
  function automatic clamp_t clamp_mag(input logic [63:0] mag, input logic neg);
    clamp_t c;
    if (neg) begin
      c.sat = (mag > 64'h0000_0000_8000_0000);
      c.val = c.sat ? 32'h8000_0000 : (32'd0 - mag[DATA_W-1:0]);
    end else begin
      c.sat = (mag > 64'h0000_0000_7FFF_FFFF);
      c.val = c.sat ? 32'h7FFF_FFFF : mag[DATA_W-1:0];
    end
    return c;
  endfunction

  // Clamp a signed 64-bit value to 32 bits.
  function automatic clamp_t clamp_s64(input logic signed [63:0] v);
    clamp_t c;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      c.sat = 1'b1;
      c.val = 32'h7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      c.sat = 1'b1;
      c.val = 32'h8000_0000;
    end else begin
      c.sat = 1'b0;
      c.val = v[DATA_W-1:0];
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/fixed_point_alu.sv -----
// Top level of the pipelined signed fixed-point ALU.
// Signed Q-format ALU on 32-bit raw values with FRAC_BITS fraction bits. Every
// request beat yields exactly one result beat, in order. The datapath is a
// fixed pipeline of 35 register stages (operand capture, 33 restoring-division
// steps of one quotient bit each, rounding): every operation leaves from the last
// stage, and a new beat is taken every cycle while the result side keeps up.
// The whole pipeline advances together: in_ready drops only when the output
// stage holds a beat that out_ready does not take. Out-of-range results clamp
// with status 1; division by zero returns 0 with status 2.
module fixed_point_alu import fpa_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [3:0]               in_req_type,
  input  logic signed [DATA_W-1:0] in_operand_a,
  input  logic signed [DATA_W-1:0] in_operand_b,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_result_value,
  output logic                     out_compare_true,
  output logic [1:0]               out_status
);

  logic               adv;
  op_t                op;
  logic signed [32:0] sum_w;
  logic signed [32:0] dif_w;
  logic signed [32:0] inc_w;
  logic signed [32:0] dec_w;
  logic signed [63:0] i2f_w;
  clamp_t             cl;
  meta_t              meta_nxt;
  meta_t              meta_r [PIPE_LAT];
  meta_t              mul_merge;
  logic [DATA_W-1:0]  mul_res;
  logic               mul_sat;
  logic [DATA_W-1:0]  div_res;
  logic               div_sat;

  assign adv      = !meta_r[PIPE_LAT-1].valid || out_ready;
  assign in_ready = adv;
  assign op       = op_t'(in_req_type);

  // Combinational operations resolved at entry
  always_comb begin
    sum_w = 33'(in_operand_a) + 33'(in_operand_b);
    dif_w = 33'(in_operand_a) - 33'(in_operand_b);
    inc_w = 33'(in_operand_a) + 33'sd1;
    dec_w = 33'(in_operand_a) - 33'sd1;
    i2f_w = 64'(in_operand_a) <<< FRAC_BITS;
    cl    = '0;
    meta_nxt       = '0;
    meta_nxt.valid = in_valid;
    meta_nxt.op    = op;
    meta_nxt.st    = ST_OK;
    case (op)
      OP_ADD: cl = clamp_s64(64'(sum_w));
      OP_SUB: cl = clamp_s64(64'(dif_w));
      OP_INC: cl = clamp_s64(64'(inc_w));
      OP_DEC: cl = clamp_s64(64'(dec_w));
      OP_I2F: cl = clamp_s64(i2f_w);
      default: cl = '0;
    endcase
    case (op)
      OP_ADD, OP_SUB, OP_INC, OP_DEC, OP_I2F: begin
        meta_nxt.res = cl.val;
        meta_nxt.st  = cl.sat ? ST_SAT : ST_OK;
      end
      OP_DIV: meta_nxt.st = (in_operand_b == '0) ? ST_DIVZERO : ST_OK;
      OP_GT:  meta_nxt.cmp = (in_operand_a >  in_operand_b);
      OP_LT:  meta_nxt.cmp = (in_operand_a <  in_operand_b);
      OP_GE:  meta_nxt.cmp = (in_operand_a >= in_operand_b);
      OP_LE:  meta_nxt.cmp = (in_operand_a <= in_operand_b);
      OP_EQ:  meta_nxt.cmp = (in_operand_a == in_operand_b);
      OP_NE:  meta_nxt.cmp = (in_operand_a != in_operand_b);
      OP_MIN: meta_nxt.res = (in_operand_a < in_operand_b) ? in_operand_a : in_operand_b;
      OP_MAX: meta_nxt.res = (in_operand_a > in_operand_b) ? in_operand_a : in_operand_b;
      OP_F2I: meta_nxt.res = in_operand_a >>> FRAC_BITS;
      default: meta_nxt.res = '0;
    endcase
  end

  fpa_mul u_mul (
    .clk (clk),
    .en  (adv),
    .a   (in_operand_a),
    .b   (in_operand_b),
    .res (mul_res),
    .sat (mul_sat)
  );

  fpa_divider u_div (
    .clk (clk),
    .en  (adv),
    .a   (in_operand_a),
    .b   (in_operand_b),
    .res (div_res),
    .sat (div_sat)
  );

  // Multiplier result joins the side data after its two stages
  always_comb begin
    mul_merge = meta_r[1];
    if (meta_r[1].op == OP_MUL) begin
      mul_merge.res = mul_res;
      mul_merge.st  = mul_sat ? ST_SAT : ST_OK;
    end
  end

  // Side-data pipeline; valid bits reset, payload does not need it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PIPE_LAT; i++) begin
        meta_r[i].valid <= 1'b0;
      end
    end else if (adv) begin
      meta_r[0] <= meta_nxt;
      meta_r[2] <= mul_merge;
      meta_r[1] <= meta_r[0];
      for (int i = 3; i < PIPE_LAT; i++) begin
        meta_r[i] <= meta_r[i-1];
      end
    end
  end

  // Output: divider result joins at the last stage
  always_comb begin
    out_valid        = meta_r[PIPE_LAT-1].valid;
    out_compare_true = meta_r[PIPE_LAT-1].cmp;
    out_result_value = meta_r[PIPE_LAT-1].res;
    out_status       = meta_r[PIPE_LAT-1].st;
    if (meta_r[PIPE_LAT-1].op == OP_DIV && meta_r[PIPE_LAT-1].st != ST_DIVZERO) begin
      out_result_value = div_res;
      out_status       = div_sat ? ST_SAT : ST_OK;
    end
  end

`ifndef ASSERT_OFF
  a_cmp_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_compare_true) |-> (out_result_value == '0 && out_status == ST_OK))
    else $error("compare result carries value or status");

  a_divzero_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_DIVZERO) |-> (out_result_value == '0))
    else $error("division by zero with nonzero value");

  a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_SAT) |->
      (out_result_value == 32'sh7FFF_FFFF || out_result_value == -32'sh8000_0000))
    else $error("saturated value not at a bound");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_result_value)))
    else $error("result beat changed while stalled");
`endif

endmodule

// ----- rtl/core/fpa_mul.sv -----
// Two-stage fixed-point multiplier: product, then rounding and saturation.
module fpa_mul import fpa_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [DATA_W-1:0] a,
  input  logic signed [DATA_W-1:0] b,
  output logic signed [DATA_W-1:0] res,
  output logic                     sat
);

  logic signed [63:0] prod_r;
  logic [63:0]        mag;
  logic [63:0]        rnd;
  clamp_t             cl;
  logic [DATA_W-1:0]  res_r;
  logic               sat_r;

  // Round half away from zero on the magnitude
  always_comb begin
    mag = prod_r[63] ? (64'd0 - prod_r) : prod_r;
    rnd = (mag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    cl  = clamp_mag(rnd, prod_r[63]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= 64'(a) * 64'(b);
      res_r  <= cl.val;
      sat_r  <= cl.sat;
    end
  end

  assign res = res_r;
  assign sat = sat_r;

endmodule

// ----- rtl/core/fpa_div_stage.sv -----
// One restoring-division step: one quotient bit per register stage.
module fpa_div_stage import fpa_pkg::*; (
  input  logic      clk,
  input  logic      en,
  input  div_step_t din,
  output div_step_t dout
);

  logic [DATA_W:0] trial;
  logic            ge;
  div_step_t       step_nxt;
  div_step_t       step_r;

  // Shift in the next dividend bit and try to subtract the divisor
  always_comb begin
    trial    = {din.rem, din.nlow[DIV_STEPS-1]};
    ge       = (trial >= {1'b0, din.dvs});
    step_nxt = din;
    step_nxt.rem  = ge ? DATA_W'(trial - {1'b0, din.dvs}) : trial[DATA_W-1:0];
    step_nxt.nlow = {din.nlow[DIV_STEPS-2:0], 1'b0};
    step_nxt.quo  = {din.quo[DIV_STEPS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      step_r <= step_nxt;
    end
  end

  assign dout = step_r;

endmodule

// ----- rtl/core/fpa_divider.sv -----
// Pipelined fixed-point divider: prep stage, one stage per quotient bit, rounding stage.
module fpa_divider import fpa_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [DATA_W-1:0] a,
  input  logic signed [DATA_W-1:0] b,
  output logic signed [DATA_W-1:0] res,
  output logic                     sat
);

  logic [DATA_W-1:0] mag_a;
  logic [DATA_W-1:0] mag_b;
  logic [63:0]       num;
  logic [30:0]       num_hi;
  div_step_t         prep_nxt;
  div_step_t         chain [DIV_STEPS+1];
  logic              rup;
  logic [63:0]       qmag;
  clamp_t            cl;
  logic [DATA_W-1:0] res_r;
  logic              sat_r;

  // Prep: magnitudes, scaled dividend, early overflow when quotient >= 2^33
  always_comb begin
    mag_a    = a[DATA_W-1] ? (DATA_W'(0) - a) : a;
    mag_b    = b[DATA_W-1] ? (DATA_W'(0) - b) : b;
    num      = {32'd0, mag_a} << FRAC_BITS;
    num_hi   = num[63:33];
    prep_nxt.ovf  = ({1'b0, num_hi} >= mag_b);
    prep_nxt.rem  = prep_nxt.ovf ? DATA_W'(0) : {1'b0, num_hi};
    prep_nxt.nlow = num[DIV_STEPS-1:0];
    prep_nxt.quo  = '0;
    prep_nxt.dvs  = mag_b;
    prep_nxt.neg  = a[DATA_W-1] ^ b[DATA_W-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      chain[0] <= prep_nxt;
    end
  end

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
    fpa_div_stage u_stage (
      .clk  (clk),
      .en   (en),
      .din  (chain[i]),
      .dout (chain[i+1])
    );
  end

  // Round to nearest, half away from zero: bump when 2*rem >= divisor
  always_comb begin
    rup  = ({chain[DIV_STEPS].rem, 1'b0} >= {1'b0, chain[DIV_STEPS].dvs});
    qmag = {31'd0, chain[DIV_STEPS].quo} + {63'd0, rup};
    cl   = clamp_mag(qmag, chain[DIV_STEPS].neg);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (chain[DIV_STEPS].ovf) begin
        sat_r <= 1'b1;
        res_r <= chain[DIV_STEPS].neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
        sat_r <= cl.sat;
        res_r <= cl.val;
      end
    end
  end

  assign res = res_r;
  assign sat = sat_r;

endmodule
